FILE: sv/pss_pkg.sv
package pss_pkg;

  // Field and register widths
  localparam int unsigned LOC_W      = 10;
  localparam int unsigned SETPT_W    = 10;
  localparam int unsigned PULSE_W    = 10;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned PERIOD_W   = 25;
  localparam int unsigned DUTY_W     = 25;
  localparam int unsigned ERR_W      = 12;
  localparam int unsigned INTEG_W    = 13;
  localparam int unsigned DER_W      = 13;
  localparam int unsigned CORR_W     = 39;
  localparam int unsigned FRAC_W     = 16;

  // Stream and configuration port widths
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;

  // Duty split: period = 1000 * quotient + remainder
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned RECIP_W    = 23;
  // ceil(2^29 / 125); x / 1000 = ((x >> 3) * RecipM) >> 29 for x < 2^25
  localparam logic [RECIP_W-1:0] RecipM = 23'd4294968;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam logic [DUTY_W-1:0] DutyMax = 25'd33554431;

  // Command codes
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SETPOINT      = 3'd0;
  localparam cfg_idx_t REG_GAIN_P        = 3'd1;
  localparam cfg_idx_t REG_GAIN_I        = 3'd2;
  localparam cfg_idx_t REG_GAIN_D        = 3'd3;
  localparam cfg_idx_t REG_PULSE_FLOOR   = 3'd4;
  localparam cfg_idx_t REG_PULSE_CEILING = 3'd5;
  localparam cfg_idx_t REG_PWM_PERIOD    = 3'd6;

  // Reset values
  localparam logic [SETPT_W-1:0]  RstSetpoint = 10'd165;
  localparam logic [GAIN_W-1:0]   RstGainP    = 24'd2195;
  localparam logic [GAIN_W-1:0]   RstGainI    = 24'd0;
  localparam logic [GAIN_W-1:0]   RstGainD    = 24'd1901;
  localparam logic [PULSE_W-1:0]  RstFloor    = 10'd20;
  localparam logic [PULSE_W-1:0]  RstCeiling  = 10'd130;
  localparam logic [PERIOD_W-1:0] RstPeriod   = 25'd20000000;
  localparam logic [PULSE_W-1:0]  RstPulse    = 10'd75;

  // Request from the pulse stage into the duty stage
  typedef struct packed {
    logic               load;
    logic [PULSE_W-1:0] pulse;
  } duty_req_t;

endpackage

FILE: sv/pss_duty.sv
module pss_duty (
  input  logic                          clk_i,
  input  logic [pss_pkg::PERIOD_W-1:0]  period_i,
  input  pss_pkg::duty_req_t            req_i,
  output logic [pss_pkg::PULSE_W-1:0]   pulse_o,
  output logic [pss_pkg::DUTY_W-1:0]    duty_o
);
  import pss_pkg::*;

  localparam int unsigned QPROD_W = PERIOD_W - 3 + RECIP_W;
  localparam int unsigned RPROD_W = REM_W + PULSE_W - 3 + RECIP_W;
  localparam int unsigned QP_W    = QUO_W + PULSE_W;
  localparam int unsigned RP_W    = REM_W + PULSE_W;
  localparam int unsigned PART_W  = RPROD_W - RECIP_SHIFT;

  logic [QUO_W-1:0]    quo_q;
  logic [REM_W-1:0]    rem_q;
  logic [QPROD_W-1:0]  quo_prod;
  logic [QP_W-1:0]     quo_k;
  logic [PERIOD_W-1:0] rem_full;
  logic [QP_W-1:0]     qp_q;
  logic [RP_W-1:0]     rp_q;
  logic [PULSE_W-1:0]  pulse_q;
  logic [RPROD_W-1:0]  part_prod;
  logic [PART_W-1:0]   part;
  logic [QP_W:0]       duty_sum;

  // Split the period into a quotient and remainder of 1000; it only
  // changes on a configuration write, and both parts are registered.
  assign quo_prod = QPROD_W'(period_i[PERIOD_W-1:3]) * QPROD_W'(RecipM);
  assign quo_k    = QP_W'(quo_q) * QP_W'(1000);
  assign rem_full = period_i - quo_k[PERIOD_W-1:0];

  always_ff @(posedge clk_i) begin
    quo_q <= quo_prod[QPROD_W-1:RECIP_SHIFT];
    rem_q <= rem_full[REM_W-1:0];
  end

  // Multiply both parts by the pulse.
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      qp_q    <= QP_W'(quo_q) * QP_W'(req_i.pulse);
      rp_q    <= RP_W'(rem_q) * RP_W'(req_i.pulse);
      pulse_q <= req_i.pulse;
    end
  end

  // Remainder part divided by 1000, added, then saturated to the duty width.
  assign part_prod = RPROD_W'(rp_q[RP_W-1:3]) * RPROD_W'(RecipM);
  assign part      = part_prod[RPROD_W-1:RECIP_SHIFT];
  assign duty_sum  = (QP_W+1)'(qp_q) + (QP_W+1)'(part);

  always_comb begin
    if (duty_sum > (QP_W+1)'(DutyMax)) begin
      duty_o = DutyMax;
    end else begin
      duty_o = duty_sum[DUTY_W-1:0];
    end
  end

  assign pulse_o = pulse_q;

endmodule

FILE: sv/pid_servo_pulse_steering.sv
// An accepted input request passes through stages 1 to 4 and then the output register.
// Throughput: one request per cycle unless the output stalls; the servo pulse loop
// closes in stage 3 (subtract, floor, clamp); the three gain multiplies sit in stage 2.
// Reset: registers take their documented reset values, the integral and last
// error clear to zero, the servo pulse starts at 75 and the pipeline empties.
module pid_servo_pulse_steering #(
  parameter int INTEGRAL_LIMIT = 3000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pss_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [9:0] location
  input  logic                            s_axis_tuser,  // [0] command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pss_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [9:0] pulse, [34:10] duty
);
  import pss_pkg::*;

  localparam int unsigned ACC_W = INTEG_W + 1;
  localparam int unsigned V_W   = CORR_W + 1;
  localparam int unsigned Q_W   = V_W - FRAC_W;
  localparam logic signed [ACC_W-1:0] LimPos = ACC_W'(INTEGRAL_LIMIT);
  localparam logic signed [ACC_W-1:0] LimNeg = -LimPos;

  // Configuration registers
  logic        [SETPT_W-1:0]  setpoint_q;
  logic signed [GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
  logic        [PULSE_W-1:0]  floor_q, ceiling_q;
  logic        [PERIOD_W-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= RstSetpoint;
      gain_p_q   <= RstGainP;
      gain_i_q   <= RstGainI;
      gain_d_q   <= RstGainD;
      floor_q    <= RstFloor;
      ceiling_q  <= RstCeiling;
      period_q   <= RstPeriod;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SETPOINT:      setpoint_q <= cfg_data_i[SETPT_W-1:0];
        REG_GAIN_P:        gain_p_q   <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:        gain_i_q   <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:        gain_d_q   <= cfg_data_i[GAIN_W-1:0];
        REG_PULSE_FLOOR:   floor_q    <= cfg_data_i[PULSE_W-1:0];
        REG_PULSE_CEILING: ceiling_q  <= cfg_data_i[PULSE_W-1:0];
        REG_PWM_PERIOD:    period_q   <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: each stage moves when the next one is free or moving.
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic ready1, ready2, ready3, ready4, ready5;
  logic load1;

  assign ready5        = !out_valid_q || m_axis_tready;
  assign ready4        = !v4_q || ready5;
  assign ready3        = !v3_q || ready4;
  assign ready2        = !v2_q || ready3;
  assign ready1        = !v1_q || ready2;
  assign s_axis_tready = ready1;
  assign load1         = s_axis_tvalid && ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready1) v1_q        <= s_axis_tvalid;
      if (ready2) v2_q        <= v1_q;
      if (ready3) v3_q        <= v2_q;
      if (ready4) v4_q        <= v3_q;
      if (ready5) out_valid_q <= v4_q;
    end
  end

  // Stage 1: error, clamped integral and derivative; integral state updates here.
  logic signed [INTEG_W-1:0] integ_q, acc_c, acc1_q;
  logic signed [ERR_W-1:0]   prev_q, err_d, err1_q;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [DER_W-1:0]   der_d, der1_q;
  logic                      clr1_q;
  logic                      cmd_clear;

  assign cmd_clear = (s_axis_tuser == CMD_CLEAR);
  assign err_d   = $signed({2'b00, setpoint_q}) - $signed({2'b00, s_axis_tdata[LOC_W-1:0]});
  assign acc_sum = {integ_q[INTEG_W-1], integ_q} + ACC_W'(err_d);
  assign der_d   = DER_W'(err_d) - DER_W'(prev_q);

  always_comb begin
    priority if (acc_sum > LimPos) begin
      acc_c = LimPos[INTEG_W-1:0];
    end else if (acc_sum < LimNeg) begin
      acc_c = LimNeg[INTEG_W-1:0];
    end else begin
      acc_c = acc_sum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (load1) begin
      if (cmd_clear) begin
        integ_q <= '0;
        prev_q  <= '0;
      end else begin
        integ_q <= acc_c;
        prev_q  <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      clr1_q <= cmd_clear;
      err1_q <= err_d;
      acc1_q <= acc_c;
      der1_q <= der_d;
    end
  end

  // Stage 2: Q16 correction from the three gains.
  logic signed [CORR_W-1:0] corr_d, corr2_q;
  logic                     clr2_q;

  assign corr_d = CORR_W'(gain_p_q) * CORR_W'(err1_q)
                + CORR_W'(gain_i_q) * CORR_W'(acc1_q)
                + CORR_W'(gain_d_q) * CORR_W'(der1_q);

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      clr2_q  <= clr1_q;
      corr2_q <= corr_d;
    end
  end

  // Stage 3: subtract the correction, round toward minus infinity, clamp.
  logic        [PULSE_W-1:0] pulse_q, pulse_c;
  logic signed [V_W-1:0]     v_d;
  logic signed [Q_W-1:0]     q_d;

  assign v_d = $signed({{(V_W-PULSE_W-FRAC_W){1'b0}}, pulse_q, {FRAC_W{1'b0}}})
             - V_W'(corr2_q);
  assign q_d = v_d[V_W-1:FRAC_W];

  always_comb begin
    priority if (q_d < $signed({{(Q_W-PULSE_W){1'b0}}, floor_q})) begin
      pulse_c = floor_q;
    end else if (q_d > $signed({{(Q_W-PULSE_W){1'b0}}, ceiling_q})) begin
      pulse_c = ceiling_q;
    end else begin
      pulse_c = q_d[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= RstPulse;
    end else if (ready3 && v2_q && !clr2_q) begin
      pulse_q <= pulse_c;
    end
  end

  // Stage 4 and duty arithmetic.
  duty_req_t          duty_req;
  logic [PULSE_W-1:0] pulse4;
  logic [DUTY_W-1:0]  duty4;

  assign duty_req.load  = ready4 && v3_q;
  assign duty_req.pulse = pulse_q;

  pss_duty u_duty (
    .clk_i    (clk_i),
    .period_i (period_q),
    .req_i    (duty_req),
    .pulse_o  (pulse4),
    .duty_o   (duty4)
  );

  // Stage 5: output register.
  logic [PULSE_W-1:0] out_pulse_q;
  logic [DUTY_W-1:0]  out_duty_q;

  always_ff @(posedge clk_i) begin
    if (ready5 && v4_q) begin
      out_pulse_q <= pulse4;
      out_duty_q  <= duty4;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-DUTY_W-PULSE_W){1'b0}}, out_duty_q, out_pulse_q};

endmodule
